/* sv/mbet_pkg.sv */
// ----------------------------------------------------------------------------
// mbet_pkg: shared definitions for the escape-time pixel engine
// Register codes, reset values, field widths and the back-end state type.
// ----------------------------------------------------------------------------
package mbet_pkg;

	// default sizes handed to the top level
	localparam int COORD_WIDTH_DEF       = 32;
	localparam int PIXEL_INDEX_WIDTH_DEF = 12;

	// fixed field widths
	localparam int ORIGIN_W   = 32;
	localparam int STEP_W     = 31;
	localparam int ITER_W     = 16;
	localparam int HUE_W      = 9;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// limb width of the product units
	localparam int LIMB_W = 32;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// hue wraps at one full turn
	localparam int HUE_MOD = 360;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_X_LEFT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_Y_TOP    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_X_STEP   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_STEP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 3'd4;

	// reset values (Q4.28)
	localparam logic [ORIGIN_W-1:0] X_LEFT_RST   = 32'hE000_0000;
	localparam logic [ORIGIN_W-1:0] Y_TOP_RST    = 32'hE800_0000;
	localparam logic [STEP_W-1:0]   X_STEP_RST   = 31'd419430;
	localparam logic [STEP_W-1:0]   Y_STEP_RST   = 31'd745654;
	localparam logic [ITER_W-1:0]   MAX_ITER_RST = 16'd1000;

	// viewport registers seen by the front end
	typedef struct packed {
		logic [ORIGIN_W-1:0] x_left;
		logic [ORIGIN_W-1:0] y_top;
		logic [STEP_W-1:0]   x_step;
		logic [STEP_W-1:0]   y_step;
	} view_cfg_t;

	// back-end sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_WAIT,
		ST_UPDATE,
		ST_DONE
	} core_state_t;

endpackage

/* sv/mbet_fifo.sv */
// ----------------------------------------------------------------------------
// mbet_fifo: short item queue
// Register-based FIFO parting the coordinate front end from the iteration back.
// ----------------------------------------------------------------------------
module mbet_fifo #(
	parameter int WIDTH = 64,
	parameter int DEPTH = mbet_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic             nonempty,
	output logic [WIDTH-1:0] rdata
);
	import mbet_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;
	assign rdata    = mem_q[rd_ptr_q];

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* sv/mbet_front.sv */
// ----------------------------------------------------------------------------
// mbet_front: pixel coordinate front end
// Accepts column/row items, scales them by the step registers and pushes
// the point c in internal fixed point into the queue.
// ----------------------------------------------------------------------------
module mbet_front #(
	parameter int COORD_WIDTH       = mbet_pkg::COORD_WIDTH_DEF,
	parameter int PIXEL_INDEX_WIDTH = mbet_pkg::PIXEL_INDEX_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mbet_pkg::view_cfg_t            cfg,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [PIXEL_INDEX_WIDTH-1:0]   column,
	input  logic [PIXEL_INDEX_WIDTH-1:0]   row,
	output logic                           q_push,
	output logic [2*COORD_WIDTH-1:0]       q_data,
	input  logic                           q_full
);
	import mbet_pkg::*;

	localparam int CW     = COORD_WIDTH;
	localparam int PROD_W = PIXEL_INDEX_WIDTH + STEP_W;
	localparam int RAW_W  = PROD_W + 2;

	localparam logic signed [RAW_W-1:0] RAW_MAX = RAW_W'((64'sd1 <<< 31) - 64'sd1);
	localparam logic signed [RAW_W-1:0] RAW_MIN = -RAW_MAX - RAW_W'(1);

	logic              s1_vld_q;
	logic [PROD_W-1:0] prod_x_s1;
	logic [PROD_W-1:0] prod_y_s1;
	logic              accept;
	logic [31:0]       cx32;
	logic [31:0]       cy32;
	logic [CW-1:0]     cx;
	logic [CW-1:0]     cy;

	// origin + index*step, clamped to the 32-bit Q4.28 range
	function automatic logic [31:0] clamp_coord(input logic [ORIGIN_W-1:0] origin,
			input logic [PROD_W-1:0] prod);
		logic signed [RAW_W-1:0] raw;
		raw = RAW_W'($signed(origin)) + $signed({2'b00, prod});
		if (raw > RAW_MAX) begin
			return 32'h7FFF_FFFF;
		end else if (raw < RAW_MIN) begin
			return 32'h8000_0000;
		end
		return raw[31:0];
	endfunction

	assign in_stall = s1_vld_q && q_full;
	assign accept   = in_valid && !in_stall;
	assign q_push   = s1_vld_q;

	// stage 1: index times step
	always_ff @(posedge clk) begin
		if (accept) begin
			prod_x_s1 <= column * cfg.x_step;
			prod_y_s1 <= row * cfg.y_step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
		end else if (accept) begin
			s1_vld_q <= 1'b1;
		end else if (!q_full) begin
			s1_vld_q <= 1'b0;
		end
	end

	// add origin and clamp
	assign cx32 = clamp_coord(cfg.x_left, prod_x_s1);
	assign cy32 = clamp_coord(cfg.y_top, prod_y_s1);

	// scale Q4.28 to the internal Q4 format
	generate
		if (CW >= 32) begin : g_widen
			assign cx = CW'($signed(cx32)) <<< (CW - 32);
			assign cy = CW'($signed(cy32)) <<< (CW - 32);
		end else begin : g_narrow
			assign cx = CW'($signed(cx32) >>> (32 - CW));
			assign cy = CW'($signed(cy32) >>> (32 - CW));
		end
	endgenerate

	assign q_data = {cx, cy};

endmodule

/* sv/mbet_mul.sv */
// ----------------------------------------------------------------------------
// mbet_mul: fixed-point product unit
// Signed-magnitude Q4 product built from 32x32 limb products, one a cycle,
// then floor-shifted by the fraction width and saturated.
// ----------------------------------------------------------------------------
module mbet_mul #(
	parameter int COORD_WIDTH = mbet_pkg::COORD_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [COORD_WIDTH-1:0] a,
	input  logic [COORD_WIDTH-1:0] b,
	output logic                   done,
	output logic [COORD_WIDTH-1:0] res
);
	import mbet_pkg::*;

	localparam int CW    = COORD_WIDTH;
	localparam int LW    = LIMB_W;
	localparam int NLIMB = (CW + LW - 1) / LW;
	localparam int PAD_W = NLIMB * LW;
	localparam int ACC_W = 2 * PAD_W;
	localparam int FRAC  = CW - 4;
	localparam int QW    = ACC_W - FRAC;
	localparam int NSTEP = NLIMB * NLIMB;
	localparam int CNT_W = $clog2(NSTEP + 1);
	localparam int SH_W  = CNT_W + 1;

	localparam logic [QW:0]   Q_MAX  = (QW + 1)'({(CW - 1){1'b1}});
	localparam logic [QW:0]   Q_MIN  = Q_MAX + (QW + 1)'(1);
	localparam logic [CW-1:0] FX_MAX = {1'b0, {(CW - 1){1'b1}}};
	localparam logic [CW-1:0] FX_MIN = {1'b1, {(CW - 1){1'b0}}};

	logic [PAD_W-1:0]  mag_a_q;
	logic [PAD_W-1:0]  mag_b_q;
	logic              neg_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              run_q;
	logic              pv_q;
	logic              plast_q;
	logic              fin_q;
	logic              done_q;
	logic [2*LW-1:0]   prod_q;
	logic [SH_W-1:0]   sh_q;
	logic [ACC_W-1:0]  acc_q;
	logic [CW-1:0]     res_q;
	logic [CNT_W-1:0]  step_i;
	logic [CNT_W-1:0]  step_j;
	logic [LW-1:0]     limb_a;
	logic [LW-1:0]     limb_b;
	logic [2*LW-1:0]   prod_d;
	logic [CW-1:0]     abs_a;
	logic [CW-1:0]     abs_b;
	logic              rem_nz;
	logic [QW:0]       qr;
	logic [CW-1:0]     res_d;

	// magnitudes of the operands
	assign abs_a = a[CW-1] ? CW'(~a + 1'b1) : a;
	assign abs_b = b[CW-1] ? CW'(~b + 1'b1) : b;

	// limb pair for this step
	assign step_i = CNT_W'(cnt_q / NLIMB);
	assign step_j = CNT_W'(cnt_q % NLIMB);
	assign limb_a = LW'(mag_a_q >> (LW * step_i));
	assign limb_b = LW'(mag_b_q >> (LW * step_j));
	assign prod_d = limb_a * limb_b;

	// floor shift with sign-aware rounding, then saturation
	assign rem_nz = |acc_q[FRAC-1:0];
	assign qr     = {1'b0, acc_q[ACC_W-1:FRAC]} + (QW + 1)'(neg_q && rem_nz);

	always_comb begin
		if (!neg_q) begin
			res_d = (qr > Q_MAX) ? FX_MAX : CW'(qr);
		end else begin
			res_d = (qr > Q_MIN) ? FX_MIN : CW'((~qr) + 1'b1);
		end
	end

	// operand, product and accumulator registers
	always_ff @(posedge clk) begin
		if (start) begin
			mag_a_q <= PAD_W'(abs_a);
			mag_b_q <= PAD_W'(abs_b);
			neg_q   <= a[CW-1] ^ b[CW-1];
		end
		if (run_q) begin
			prod_q <= prod_d;
			sh_q   <= SH_W'(step_i) + SH_W'(step_j);
		end
		if (start) begin
			acc_q <= '0;
		end else if (pv_q) begin
			acc_q <= acc_q + (ACC_W'(prod_q) << (LW * sh_q));
		end
		if (fin_q) begin
			res_q <= res_d;
		end
	end

	// step sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			run_q   <= 1'b0;
			pv_q    <= 1'b0;
			plast_q <= 1'b0;
			fin_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			pv_q    <= run_q;
			plast_q <= run_q && (cnt_q == CNT_W'(NSTEP - 1));
			fin_q   <= pv_q && plast_q;
			done_q  <= fin_q;
			if (start) begin
				cnt_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NSTEP - 1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

/* sv/mbet_core.sv */
// ----------------------------------------------------------------------------
// mbet_core: iteration back end
// Takes one point c from the queue, iterates z = z*z + c with three
// product units and delivers the escape result through an output register.
// ----------------------------------------------------------------------------
module mbet_core #(
	parameter int COORD_WIDTH = mbet_pkg::COORD_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [mbet_pkg::ITER_W-1:0]        max_iterations,
	input  logic                               q_nonempty,
	input  logic [2*COORD_WIDTH-1:0]           q_data,
	output logic                               q_pop,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               inside_res,
	output logic [mbet_pkg::ITER_W-1:0]        escape_iteration,
	output logic [mbet_pkg::HUE_W-1:0]         hue
);
	import mbet_pkg::*;

	localparam int CW = COORD_WIDTH;

	localparam logic [CW-1:0] FX_MAX  = {1'b0, {(CW - 1){1'b1}}};
	localparam logic [CW-1:0] FX_MIN  = {1'b1, {(CW - 1){1'b0}}};
	localparam logic [CW:0]   FX_FOUR = (CW + 1)'(1) << (CW - 2);

	core_state_t       state_q;
	core_state_t       state_d;
	logic [CW-1:0]     cx_q;
	logic [CW-1:0]     cy_q;
	logic [CW-1:0]     zr_q;
	logic [CW-1:0]     zi_q;
	logic [ITER_W-1:0] k_q;
	logic [HUE_W-1:0]  hue_q;
	logic              res_inside_q;
	logic [ITER_W-1:0] res_iter_q;
	logic [HUE_W-1:0]  res_hue_q;
	logic              out_vld_q;
	logic              out_inside_q;
	logic [ITER_W-1:0] out_iter_q;
	logic [HUE_W-1:0]  out_hue_q;
	logic              mul_start;
	logic              done_rr;
	logic              done_ii;
	logic              done_ri;
	logic              all_done;
	logic [CW-1:0]     rr;
	logic [CW-1:0]     ii;
	logic [CW-1:0]     ri;
	logic              escaped;
	logic              at_limit;
	logic              out_free;
	logic              load_out;
	logic [CW-1:0]     diff;
	logic [CW-1:0]     twice_ri;
	logic [CW-1:0]     zr_new;
	logic [CW-1:0]     zi_new;

	// saturate a one-bit-wider sum to the coordinate range
	function automatic logic [CW-1:0] sat(input logic [CW:0] v);
		if (v[CW] != v[CW-1]) begin
			return v[CW] ? FX_MIN : FX_MAX;
		end
		return v[CW-1:0];
	endfunction

	// product units: re^2, im^2 and re*im of the current z
	mbet_mul #(.COORD_WIDTH(CW)) u_mul_rr (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(zr_q), .b(zr_q), .done(done_rr), .res(rr)
	);
	mbet_mul #(.COORD_WIDTH(CW)) u_mul_ii (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(zi_q), .b(zi_q), .done(done_ii), .res(ii)
	);
	mbet_mul #(.COORD_WIDTH(CW)) u_mul_ri (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(zr_q), .b(zi_q), .done(done_ri), .res(ri)
	);

	assign all_done = done_rr && done_ii && done_ri;

	// escape test on |z|^2; squares are never negative so no saturation needed
	assign escaped  = (k_q != '0) && (({1'b0, rr} + {1'b0, ii}) >= FX_FOUR);
	assign at_limit = (k_q == max_iterations);

	// next z: re = rr - ii + cx, im = 2*ri + cy, each sum saturated
	assign diff     = CW'({rr[CW-1], rr} - {ii[CW-1], ii});
	assign zr_new   = sat({diff[CW-1], diff} + {cx_q[CW-1], cx_q});
	assign twice_ri = sat({ri, 1'b0});
	assign zi_new   = sat({twice_ri[CW-1], twice_ri} + {cy_q[CW-1], cy_q});

	assign out_free = !out_vld_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_nonempty) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (all_done) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_d = (escaped || at_limit) ? ST_DONE : ST_MUL;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		q_pop     = 1'b0;
		mul_start = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE:   q_pop     = q_nonempty;
			ST_MUL:    mul_start = 1'b1;
			ST_DONE:   load_out  = out_free;
			default: begin
				q_pop     = 1'b0;
				mul_start = 1'b0;
				load_out  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// iterate and result registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cx_q  <= q_data[2*CW-1:CW];
			cy_q  <= q_data[CW-1:0];
			zr_q  <= '0;
			zi_q  <= '0;
			k_q   <= '0;
			hue_q <= HUE_W'(HUE_MOD - 1);
		end else if (state_q == ST_UPDATE) begin
			if (escaped) begin
				res_inside_q <= 1'b0;
				res_iter_q   <= k_q - 1'b1;
				res_hue_q    <= hue_q;
			end else if (at_limit) begin
				res_inside_q <= 1'b1;
				res_iter_q   <= '0;
				res_hue_q    <= '0;
			end else begin
				zr_q  <= zr_new;
				zi_q  <= zi_new;
				k_q   <= k_q + 1'b1;
				hue_q <= (hue_q == HUE_W'(HUE_MOD - 1)) ? '0 : hue_q + 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_inside_q <= res_inside_q;
			out_iter_q   <= res_iter_q;
			out_hue_q    <= res_hue_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_out) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	assign out_valid        = out_vld_q;
	assign inside_res       = out_inside_q;
	assign escape_iteration = out_iter_q;
	assign hue              = out_hue_q;

endmodule

/* sv/mandelbrot_escape_time_pixel.sv */
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel: escape-time engine for one pixel an item
// Configuration registers, coordinate front end, queue and iteration back end.
//
//  Channel  Direction  Handshake              Payload
//  in       in         in_valid / in_stall    column, row
//  out      out        out_valid / out_stall  inside_res, escape_iteration, hue
//  cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each iteration issues three limb-serial products in parallel; a pixel
// takes (escape_iteration + 2) or (max_iterations + 1) iterations, plus
// queue and output handling.
// The front end computes coordinates in one registered stage and queues two
// items ahead.
// Reset clears control state and loads the register reset values.
// Stalls on out hold the result register; in stalls only when the queue fills.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel #(
	parameter int COORD_WIDTH       = mbet_pkg::COORD_WIDTH_DEF,
	parameter int PIXEL_INDEX_WIDTH = mbet_pkg::PIXEL_INDEX_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [PIXEL_INDEX_WIDTH-1:0]     column,
	input  logic [PIXEL_INDEX_WIDTH-1:0]     row,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             inside_res,
	output logic [mbet_pkg::ITER_W-1:0]      escape_iteration,
	output logic [mbet_pkg::HUE_W-1:0]       hue,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [mbet_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mbet_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import mbet_pkg::*;

	localparam int CW = COORD_WIDTH;

	view_cfg_t         view_q;
	logic [ITER_W-1:0] max_iter_q;
	logic              q_push;
	logic [2*CW-1:0]   q_wdata;
	logic              q_full;
	logic              q_pop;
	logic              q_nonempty;
	logic [2*CW-1:0]   q_rdata;

	// configuration registers, writes always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_q.x_left <= X_LEFT_RST;
			view_q.y_top  <= Y_TOP_RST;
			view_q.x_step <= X_STEP_RST;
			view_q.y_step <= Y_STEP_RST;
			max_iter_q    <= MAX_ITER_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_X_LEFT:   view_q.x_left <= cfg_data;
				REG_Y_TOP:    view_q.y_top  <= cfg_data;
				REG_X_STEP:   view_q.x_step <= cfg_data[STEP_W-1:0];
				REG_Y_STEP:   view_q.y_step <= cfg_data[STEP_W-1:0];
				REG_MAX_ITER: max_iter_q    <= cfg_data[ITER_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// coordinate front end
	mbet_front #(
		.COORD_WIDTH(CW),
		.PIXEL_INDEX_WIDTH(PIXEL_INDEX_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(view_q),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.column(column),
		.row(row),
		.q_push(q_push),
		.q_data(q_wdata),
		.q_full(q_full)
	);

	// queue of points c
	mbet_fifo #(
		.WIDTH(2 * CW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.wdata(q_wdata),
		.full(q_full),
		.pop(q_pop),
		.nonempty(q_nonempty),
		.rdata(q_rdata)
	);

	// iteration back end
	mbet_core #(
		.COORD_WIDTH(CW)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.max_iterations(max_iter_q),
		.q_nonempty(q_nonempty),
		.q_data(q_rdata),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.inside_res(inside_res),
		.escape_iteration(escape_iteration),
		.hue(hue)
	);

endmodule
